/* src/ffba_pkg.sv */
package ffba_pkg;

    localparam int MaxBlocks   = 64;
    localparam int HeaderBytes = 16;
    localparam int AddrBits    = 20;
    localparam int IdxBits     = $clog2(MaxBlocks);
    localparam int CntBits     = $clog2(MaxBlocks + 1);
    localparam int TopBits     = AddrBits + 1;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CmdAlloc   = 2'd0;
    localparam t_cmd CmdFree    = 2'd1;
    localparam t_cmd CmdRealloc = 2'd2;
    localparam t_cmd CmdCalloc  = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status StOk       = 2'd0;
    localparam t_status StSize     = 2'd1;
    localparam t_status StSpace    = 2'd2;
    localparam t_status StNotFound = 2'd3;

    // Table entry as stored in the block memory.
    typedef struct packed {
        logic [AddrBits-1:0] start;
        logic [AddrBits-1:0] size;
        logic                free;
    } t_entry;

    // Write request from the sequencer to the block table.
    typedef struct packed {
        logic               we;
        logic [IdxBits-1:0] idx;
        t_entry             data;
    } t_tbl_wr;

endpackage

/* src/ffba_table.sv */
module ffba_table (
    input  logic                           i_clk,
    input  ffba_pkg::t_tbl_wr              i_wr,
    input  logic [ffba_pkg::IdxBits-1:0]   i_rd_idx,
    output ffba_pkg::t_entry               o_rd_data
);

    ffba_pkg::t_entry r_mem [ffba_pkg::MaxBlocks];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        o_rd_data <= r_mem[i_rd_idx];
    end

endmodule

/* src/ffba_ctrl.sv */
module ffba_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ffba_pkg::TopBits-1:0]    i_limit,
    input  logic                            i_start,
    input  ffba_pkg::t_cmd                  i_cmd,
    input  logic [ffba_pkg::AddrBits-1:0]   i_size,
    input  logic [ffba_pkg::AddrBits-1:0]   i_addr,
    input  logic [ffba_pkg::AddrBits-1:0]   i_count,
    input  logic                            i_res_ready,
    output logic                            o_idle,
    output logic                            o_res_valid,
    output logic [ffba_pkg::AddrBits-1:0]   o_res,
    output ffba_pkg::t_status               o_status,
    output ffba_pkg::t_tbl_wr               o_wr,
    output logic [ffba_pkg::IdxBits-1:0]    o_rd_idx,
    input  ffba_pkg::t_entry                i_rd
);

    localparam int AB = ffba_pkg::AddrBits;
    localparam int TB = ffba_pkg::TopBits;
    localparam int IB = ffba_pkg::IdxBits;
    localparam int CB = ffba_pkg::CntBits;
    localparam int HB = ffba_pkg::HeaderBytes;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MUL  = 10'b00_0000_0010,
        S_LRD  = 10'b00_0000_0100,
        S_LCHK = 10'b00_0000_1000,
        S_ARD  = 10'b00_0001_0000,
        S_ACHK = 10'b00_0010_0000,
        S_APP  = 10'b00_0100_0000,
        S_REL  = 10'b00_1000_0000,
        S_OUT  = 10'b01_0000_0000,
        S_WAIT = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CB-1:0] r_count, n_count;
    logic [TB-1:0] r_top, n_top;
    logic [CB-1:0] r_idx, n_idx;
    ffba_pkg::t_cmd r_cmd, n_cmd;
    logic [AB-1:0] r_size, n_size;
    logic [AB-1:0] r_addr, n_addr;
    logic [AB-1:0] r_cnt, n_cnt;
    logic [IB-1:0] r_kidx, n_kidx;
    logic [AB-1:0] r_kstart, n_kstart;
    logic [AB-1:0] r_res, n_res;
    ffba_pkg::t_status r_st, n_st;
    logic r_ovalid, n_ovalid;

    logic [2*AB-1:0] w_prod;
    logic [TB-1:0] w_limit_eff;
    logic [TB+1:0] w_need;

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;
    assign o_status    = r_st;
    assign o_rd_idx    = r_idx[IB-1:0];

    // Limit in effect is the smaller of the register and the address space.
    assign w_limit_eff = (i_limit > TB'(1 << AB)) ? TB'(1 << AB) : i_limit;
    assign w_need = (TB+2)'(r_top) + (TB+2)'(HB) + (TB+2)'(r_size);

    // Single multiplier for calloc, used in the cycle after the operands are captured.
    assign w_prod = (2*AB)'(r_size) * (2*AB)'(r_cnt);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_top    = r_top;
        n_idx    = r_idx;
        n_cmd    = r_cmd;
        n_size   = r_size;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_kidx   = r_kidx;
        n_kstart = r_kstart;
        n_res    = r_res;
        n_st     = r_st;
        n_ovalid = r_ovalid;
        o_wr     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd  = i_cmd;
                    n_size = i_size;
                    n_addr = i_addr;
                    n_cnt  = i_count;
                    n_res  = '0;
                    n_st   = ffba_pkg::StOk;
                    n_idx  = '0;
                    n_state = S_OUT;
                    case (i_cmd)
                        ffba_pkg::CmdAlloc: begin
                            if (i_size == '0) n_st = ffba_pkg::StSize;
                            else n_state = S_ARD;
                        end
                        ffba_pkg::CmdFree: begin
                            if (i_addr != '0) n_state = S_LRD;
                        end
                        ffba_pkg::CmdRealloc: begin
                            if (i_size == '0) n_st = ffba_pkg::StSize;
                            else if (i_addr == '0) n_state = S_ARD;
                            else n_state = S_LRD;
                        end
                        default: begin
                            if (i_size == '0 || i_count == '0) n_st = ffba_pkg::StSize;
                            else n_state = S_MUL;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (w_prod[2*AB-1:AB] != '0) begin
                    n_st = ffba_pkg::StSize;
                    n_state = S_OUT;
                end else begin
                    n_size = w_prod[AB-1:0];
                    n_state = S_ARD;
                end
            end
            // Lookup walk: issue read of entry r_idx.
            S_LRD: begin
                if (r_idx >= r_count) begin
                    n_st = ffba_pkg::StNotFound;
                    n_state = S_OUT;
                end else begin
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                if (!i_rd.free && (AB'(i_rd.start + AB'(HB)) == r_addr)
                        && ((TB)'(i_rd.start) + TB'(HB) < TB'(1 << AB))) begin
                    n_kidx = r_idx[IB-1:0];
                    n_kstart = i_rd.start;
                    if (r_cmd == ffba_pkg::CmdFree) begin
                        n_state = S_REL;
                    end else if (i_rd.size >= r_size) begin
                        n_res = r_addr;
                        n_state = S_OUT;
                    end else begin
                        n_idx = '0;
                        n_state = S_ARD;
                    end
                end else begin
                    n_idx = r_idx + CB'(1);
                    n_state = S_LRD;
                end
            end
            // First-fit walk.
            S_ARD: begin
                if (r_idx >= r_count) n_state = S_APP;
                else n_state = S_ACHK;
            end
            S_ACHK: begin
                if (i_rd.free && i_rd.size >= r_size) begin
                    o_wr.we = 1'b1;
                    o_wr.idx = r_idx[IB-1:0];
                    o_wr.data = i_rd;
                    o_wr.data.free = 1'b0;
                    n_res = AB'(i_rd.start + AB'(HB));
                    n_state = (r_cmd == ffba_pkg::CmdRealloc && r_addr != '0)
                              ? S_REL : S_OUT;
                end else begin
                    n_idx = r_idx + CB'(1);
                    n_state = S_ARD;
                end
            end
            S_APP: begin
                if (r_count >= CB'(ffba_pkg::MaxBlocks) || w_need > (TB+2)'(w_limit_eff)) begin
                    n_st = ffba_pkg::StSpace;
                    n_state = S_OUT;
                end else begin
                    o_wr.we = 1'b1;
                    o_wr.idx = r_count[IB-1:0];
                    o_wr.data.start = r_top[AB-1:0];
                    o_wr.data.size = r_size;
                    o_wr.data.free = 1'b0;
                    n_count = r_count + CB'(1);
                    n_top = w_need[TB-1:0];
                    n_res = AB'(r_top + TB'(HB));
                    n_state = (r_cmd == ffba_pkg::CmdRealloc && r_addr != '0)
                              ? S_REL : S_OUT;
                end
            end
            // Release block r_kidx; the count already includes any block appended above.
            S_REL: begin
                if (CB'(r_kidx) + CB'(1) == n_count) begin
                    n_top = TB'(r_kstart);
                    n_count = r_count - CB'(1);
                end else begin
                    o_wr.we = 1'b1;
                    o_wr.idx = r_kidx;
                    o_wr.data.start = r_kstart;
                    o_wr.data.size = r_cnt;
                    o_wr.data.free = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_st != ffba_pkg::StOk) n_res = '0;
                n_ovalid = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_res_ready) begin
                    n_ovalid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Keep the released block's size for the free-mark rewrite.
        if (r_state == S_LCHK) n_cnt = i_rd.size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cmd    <= n_cmd;
        r_size   <= n_size;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_kidx   <= n_kidx;
        r_kstart <= n_kstart;
        r_res    <= n_res;
        r_st     <= n_st;
    end

endmodule

/* src/first_fit_block_allocator.sv */
// First-fit heap allocator. One beat carries cmd (alloc, free, realloc, calloc)
// and its operands; one result beat returns the user address and a status.
// A zero size or a null free needs no table walk; a realloc can walk the table
// twice, and the table holds up to 64 blocks. For each table entry visited the
// read is issued on the single registered memory port and the returned entry
// is then checked, and a calloc also passes through the multiplier first.
// tready is low while an item is in progress and until its result beat has been
// taken. Table contents need no clearing after reset.
module first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [20:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cmd[1:0], req_size[21:2], addr[41:22], elem_count[61:42]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: result_addr[19:0], status[21:20]
    output logic [23:0] m_axis_tdata
);

    localparam int AB = ffba_pkg::AddrBits;
    localparam int TB = ffba_pkg::TopBits;
    localparam int IB = ffba_pkg::IdxBits;

    logic [TB-1:0] r_limit;

    ffba_pkg::t_tbl_wr w_wr;
    logic [IB-1:0] w_rd_idx;
    ffba_pkg::t_entry w_rd;
    logic [AB-1:0] w_res;
    ffba_pkg::t_status w_status;
    logic w_in_acc;

    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata = {2'b00, w_status, w_res};

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= TB'(1 << AB);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Block table.
    ffba_table u_table (
        .i_clk    (i_clk),
        .i_wr     (w_wr),
        .i_rd_idx (w_rd_idx),
        .o_rd_data(w_rd)
    );

    // Command sequencer.
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limit    (r_limit),
        .i_start    (w_in_acc),
        .i_cmd      (s_axis_tdata[1:0]),
        .i_size     (s_axis_tdata[21:2]),
        .i_addr     (s_axis_tdata[41:22]),
        .i_count    (s_axis_tdata[61:42]),
        .i_res_ready(m_axis_tready),
        .o_idle     (s_axis_tready),
        .o_res_valid(m_axis_tvalid),
        .o_res      (w_res),
        .o_status   (w_status),
        .o_wr       (w_wr),
        .o_rd_idx   (w_rd_idx),
        .i_rd       (w_rd)
    );

endmodule

/* src/ffba_checker.sv */
module ffba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A failed result never carries an address.
    a_null_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[21:20] != ffba_pkg::StOk |-> m_axis_tdata[19:0] == '0)
        else $error("nonzero address with error status");

    // No new item is taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // Accepting an item drops ready on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after accept");

    // Result stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

/* tb/sv/first_fit_block_allocator_test.sv */
`timescale 1ns / 100ps

module first_fit_block_allocator_test;

    // Expected allocator responses, held in issue order.
    class alloc_scoreboard;
        logic [19:0] blk_start [ffba_pkg::MaxBlocks];
        logic [19:0] blk_size [ffba_pkg::MaxBlocks];
        bit blk_free [ffba_pkg::MaxBlocks];
        int unsigned blk_count;
        longint unsigned top;
        longint unsigned limit;
        logic [21:0] pending [$];
        int errors;
        int checked;
        int status_seen [4];

        function void reset_state();
            blk_count = 0;
            top = 0;
            limit = 1048576;
            pending.delete();
            errors = 0;
            checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function longint unsigned cap();
            longint unsigned c;
            c = longint'(1) << ffba_pkg::AddrBits;
            return (limit < c) ? limit : c;
        endfunction

        function longint unsigned grant(longint unsigned sz, ref ffba_pkg::t_status st);
            if (sz == 0) begin
                st = ffba_pkg::StSize;
                return 0;
            end
            for (int i = 0; i < blk_count; i++) begin
                if (blk_free[i] && blk_size[i] >= sz) begin
                    blk_free[i] = 0;
                    st = ffba_pkg::StOk;
                    return blk_start[i] + ffba_pkg::HeaderBytes;
                end
            end
            if (blk_count >= ffba_pkg::MaxBlocks
                || top + ffba_pkg::HeaderBytes + sz > cap()) begin
                st = ffba_pkg::StSpace;
                return 0;
            end
            blk_start[blk_count] = top[19:0];
            blk_size[blk_count] = sz[19:0];
            blk_free[blk_count] = 0;
            blk_count++;
            top += ffba_pkg::HeaderBytes + sz;
            st = ffba_pkg::StOk;
            return top - sz;
        endfunction

        function int find_live(longint unsigned ua);
            for (int i = 0; i < blk_count; i++)
                if (!blk_free[i] && blk_start[i] + ffba_pkg::HeaderBytes == ua) return i;
            return -1;
        endfunction

        function void release_blk(int i);
            if (i + 1 == blk_count) begin
                top = blk_start[i];
                blk_count--;
            end else begin
                blk_free[i] = 1;
            end
        endfunction

        // Notes an accepted command beat and queues its response.
        function void note_command(ffba_pkg::t_cmd cmd, logic [19:0] sz, logic [19:0] ua,
                                   logic [19:0] cnt);
            longint unsigned res;
            longint unsigned prod;
            ffba_pkg::t_status st;
            int k;
            res = 0;
            st = ffba_pkg::StOk;
            case (cmd)
                ffba_pkg::CmdAlloc: res = grant(sz, st);
                ffba_pkg::CmdFree: begin
                    if (ua != 0) begin
                        k = find_live(ua);
                        if (k < 0) st = ffba_pkg::StNotFound;
                        else release_blk(k);
                    end
                end
                ffba_pkg::CmdRealloc: begin
                    if (ua == 0 || sz == 0) begin
                        res = grant(sz, st);
                    end else begin
                        k = find_live(ua);
                        if (k < 0) st = ffba_pkg::StNotFound;
                        else if (blk_size[k] >= sz) res = ua;
                        else begin
                            res = grant(sz, st);
                            if (st == ffba_pkg::StOk) release_blk(k);
                        end
                    end
                end
                default: begin
                    prod = longint'(cnt) * longint'(sz);
                    if (cnt == 0 || sz == 0 || prod >= (longint'(1) << ffba_pkg::AddrBits))
                        st = ffba_pkg::StSize;
                    else res = grant(prod, st);
                end
            endcase
            if (st != ffba_pkg::StOk) res = 0;
            pending.push_back({st, res[19:0]});
        endfunction

        // Compares one response beat with the oldest expectation.
        function void check_response(logic [23:0] data);
            logic [21:0] exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response %h", data);
                return;
            end
            exp = pending.pop_front();
            checked++;
            status_seen[exp[21:20]]++;
            if (data[19:0] !== exp[19:0] || data[21:20] !== exp[21:20]
                || data[23:22] !== 2'b00) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                             exp[19:0], exp[21:20], data[19:0], data[21:20]);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [20:0] i_cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [23:0] m_axis_tdata;

    alloc_scoreboard sb;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    logic [19:0] live_addrs [$];

    first_fit_block_allocator uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Clock.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog on total cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Response side: random stalls, a forced hold when asked, checking on each beat.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_response(m_axis_tdata);
            if (m_axis_tdata[21:20] == ffba_pkg::StOk && m_axis_tdata[19:0] != 0)
                live_addrs.push_back(m_axis_tdata[19:0]);
        end
        m_axis_tready <= !recv_hold && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Sends one command beat and records it once accepted; tvalid stays up for the next one.
    task automatic send_cmd(ffba_pkg::t_cmd cmd, logic [19:0] sz, logic [19:0] ua,
                            logic [19:0] cnt);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, cnt, ua, sz, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, sz, ua, cnt);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * ffba_pkg::MaxBlocks + 20) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [20:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.limit = value;
    endtask

    // Picks an address that is likely live, or sometimes a stale or random one.
    function automatic logic [19:0] pick_addr();
        int r;
        r = $urandom_range(99, 0);
        if (live_addrs.size() != 0 && r < 80)
            return live_addrs[$urandom_range(live_addrs.size() - 1, 0)];
        if (r < 90) return 20'($urandom_range(63, 0) * 16 + 16);
        return 20'($urandom);
    endfunction

    function automatic logic [19:0] pick_size();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return 20'($urandom_range(256, 1));
        if (r < 85) return 20'($urandom_range(4096, 0));
        return 20'($urandom);
    endfunction

    task automatic random_phase(int count);
        ffba_pkg::t_cmd cmd;
        logic [19:0] ua;
        for (int n = 0; n < count; n++) begin
            cmd = ffba_pkg::t_cmd'($urandom_range(3, 0));
            case (cmd)
                ffba_pkg::CmdAlloc:
                    send_cmd(cmd, pick_size(), 20'($urandom), 20'($urandom));
                ffba_pkg::CmdFree: begin
                    ua = ($urandom_range(19, 0) == 0) ? 20'd0 : pick_addr();
                    send_cmd(cmd, 20'($urandom), ua, 20'($urandom));
                end
                ffba_pkg::CmdRealloc: begin
                    ua = ($urandom_range(9, 0) == 0) ? 20'd0 : pick_addr();
                    send_cmd(cmd, pick_size(), ua, 20'($urandom));
                end
                default: begin
                    ua = 20'($urandom);
                    if ($urandom_range(9, 0) == 0)
                        send_cmd(cmd, 20'($urandom), ua, 20'($urandom));
                    else
                        send_cmd(cmd, 20'($urandom_range(64, 0)), ua,
                                 20'($urandom_range(32, 0)));
                end
            endcase
            if (live_addrs.size() > 200) void'(live_addrs.pop_front());
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero sizes, null address, extremes, lookup misses, calloc overflow.
        send_cmd(ffba_pkg::CmdAlloc, 20'd0, 20'd0, 20'd0);
        send_cmd(ffba_pkg::CmdFree, 20'hFFFFF, 20'd0, 20'hFFFFF);
        send_cmd(ffba_pkg::CmdAlloc, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        send_cmd(ffba_pkg::CmdAlloc, 20'd100, 20'd0, 20'd0);
        send_cmd(ffba_pkg::CmdAlloc, 20'd1, 20'd0, 20'd0);
        send_cmd(ffba_pkg::CmdAlloc, 20'd50, 20'd0, 20'd0);
        send_cmd(ffba_pkg::CmdFree, 20'd0, 20'd16, 20'd0);
        send_cmd(ffba_pkg::CmdFree, 20'd0, 20'd16, 20'd0);
        send_cmd(ffba_pkg::CmdFree, 20'd0, 20'd12345, 20'd0);
        send_cmd(ffba_pkg::CmdAlloc, 20'd80, 20'd0, 20'd0);
        send_cmd(ffba_pkg::CmdRealloc, 20'd10, 20'd16, 20'd0);
        send_cmd(ffba_pkg::CmdRealloc, 20'd0, 20'd16, 20'd0);
        send_cmd(ffba_pkg::CmdRealloc, 20'd500, 20'd16, 20'd0);
        send_cmd(ffba_pkg::CmdRealloc, 20'd20, 20'd0, 20'd0);
        send_cmd(ffba_pkg::CmdRealloc, 20'd20, 20'd99999, 20'd0);
        send_cmd(ffba_pkg::CmdCalloc, 20'd0, 20'd0, 20'd5);
        send_cmd(ffba_pkg::CmdCalloc, 20'd5, 20'd0, 20'd0);
        send_cmd(ffba_pkg::CmdCalloc, 20'd1024, 20'd0, 20'd1024);
        send_cmd(ffba_pkg::CmdCalloc, 20'hFFFFF, 20'd0, 20'hFFFFF);
        send_cmd(ffba_pkg::CmdCalloc, 20'd8, 20'd0, 20'd4);
        send_cmd(ffba_pkg::CmdRealloc, 20'hFFFFF, 20'd0, 20'd0);
        drain();

        // Tight limit: appends run out of room quickly.
        write_limit(21'd16);
        send_cmd(ffba_pkg::CmdAlloc, 20'd1, 20'd0, 20'd0);
        send_idle_pct = 34;
        recv_idle_pct = 34;
        random_phase(120);
        drain();
        write_limit(21'd2048);
        random_phase(200);
        drain();

        // Receiver holds off for a long stretch while commands keep coming.
        write_limit(21'h1FFFFF);
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            random_phase(20);
        join
        drain();

        // Small blocks fill the table to its capacity.
        write_limit(21'd1048576);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 70; n++) send_cmd(ffba_pkg::CmdAlloc, 20'd4, 20'd0, 20'd0);
        send_idle_pct = 34;
        recv_idle_pct = 34;
        random_phase(150);
        drain();
        write_limit(21'd65536);
        random_phase(280);
        drain();

        if (sb.pending.size() != 0) sb.errors++;
        $display("Checked %0d responses: ok %0d, size %0d, no space %0d, not found %0d.",
                 sb.checked, sb.status_seen[ffba_pkg::StOk], sb.status_seen[ffba_pkg::StSize],
                 sb.status_seen[ffba_pkg::StSpace], sb.status_seen[ffba_pkg::StNotFound]);
        $display("Limits from 16 bytes to the full range, table fill and a long output stall.");
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("Mismatches: %0d", sb.errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
src/ffba_pkg.sv
src/ffba_table.sv
src/ffba_ctrl.sv
src/first_fit_block_allocator.sv
src/ffba_checker.sv
tb/sv/first_fit_block_allocator_test.sv
